[rtl/ppa_pkg.sv]
// shared types and constants for the page pool allocator
package ppa_pkg;

   localparam int ADDR_W = 32;
   localparam int CNT_W  = 11;
   localparam int PS_W   = 18;
   localparam int PSZ_W  = 17;

   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_FREE  = 2'd1;
   localparam logic [1:0] KIND_INIT  = 2'd2;

   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_EMPTY       = 3'd1;
   localparam logic [2:0] STS_BELOW_BASE  = 3'd2;
   localparam logic [2:0] STS_MISALIGNED  = 3'd3;
   localparam logic [2:0] STS_OUT_OF_RANGE = 3'd4;
   localparam logic [2:0] STS_NOT_ALLOC   = 3'd5;

   localparam logic [1:0] CSR_POOL_BASE   = 2'd0;
   localparam logic [1:0] CSR_PAGE_SIZE   = 2'd1;
   localparam logic [1:0] CSR_TOTAL_PAGES = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] page_address;
   } ppa_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] alloc_address;
      logic [2:0]        status;
      logic [CNT_W-1:0]  free_pages;
      logic [CNT_W-1:0]  all_pages;
   } ppa_rsp_type;

   typedef struct packed {
      logic start;
      logic divide;
   } ppa_unit_cmd_type;

endpackage

[rtl/ppa_shift_add_unit.sv]
// iterative shift-add unit: restoring divide or shift-add multiply, one bit per cycle
module ppa_shift_add_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  ppa_pkg::ppa_unit_cmd_type    cmd,
   input  logic [ppa_pkg::ADDR_W-1:0]   oper_a,
   input  logic [ppa_pkg::PS_W-1:0]     oper_b,
   output logic                         done,
   output logic [ppa_pkg::ADDR_W-1:0]   acc,
   output logic [ppa_pkg::ADDR_W-1:0]   quo
);

   localparam logic [4:0] STEP_LAST = 5'd31;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        div_ff, div_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [ppa_pkg::ADDR_W-1:0]  acc_ff, acc_in;
   logic [ppa_pkg::ADDR_W-1:0]  q_ff, q_in;
   logic [ppa_pkg::PS_W-1:0]    b_ff, b_in;

   logic [ppa_pkg::PS_W:0]      shifted;
   logic [32:0]                 add_a;
   logic [32:0]                 add_b;
   logic [33:0]                 sum;
   logic                        carry;

   // one shared adder serves both operations
   always_comb begin
      shifted = {acc_ff[ppa_pkg::PS_W-1:0], q_ff[ppa_pkg::ADDR_W-1]};
      if (div_ff) begin
         add_a = 33'(shifted);
         add_b = ~(33'(b_ff));
      end else begin
         add_a = {1'b0, acc_ff[ppa_pkg::ADDR_W-2:0], 1'b0};
         add_b = q_ff[ppa_pkg::ADDR_W-1] ? 33'(b_ff) : 33'd0;
      end
      sum   = {1'b0, add_a} + {1'b0, add_b} + 34'(div_ff);
      carry = sum[33];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      b_in    = b_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.divide;
         cnt_in  = '0;
         acc_in  = '0;
         q_in    = oper_a;
         b_in    = oper_b;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (div_ff) begin
            acc_in = carry ? sum[ppa_pkg::ADDR_W-1:0] : 32'(shifted);
            q_in   = {q_ff[ppa_pkg::ADDR_W-2:0], carry};
         end else begin
            acc_in = sum[ppa_pkg::ADDR_W-1:0];
            q_in   = {q_ff[ppa_pkg::ADDR_W-2:0], 1'b0};
         end
         if (cnt_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      acc_ff <= acc_in;
      q_ff   <= q_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = q_ff;

endmodule

[rtl/page_pool_allocator_top.sv]
// page pool allocator top level: sequencer, free stack and allocated-bit map
// allocate and free: allocate multiplies and free divides in the 32-step shift-add unit
// initialize: one sweep over the map and stack
// one request at a time; the next is taken while a result waits
// after reset a clearing pass over the map and stack runs before the first request
module page_pool_allocator_top #(
   parameter int MAX_PAGES = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ppa_pkg::ppa_req_type       req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ppa_pkg::ppa_rsp_type       rsp_payload,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_data
);

   localparam int IDX_W = $clog2(MAX_PAGES);
   localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(MAX_PAGES - 1);

   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_INIT      = 3'd2;
   localparam logic [2:0] ST_ALLOC_RD  = 3'd3;
   localparam logic [2:0] ST_ALLOC_MUL = 3'd4;
   localparam logic [2:0] ST_FREE_DIV  = 3'd5;
   localparam logic [2:0] ST_FREE_MAP  = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   logic [ppa_pkg::ADDR_W-1:0]  pool_base_ff;
   logic [ppa_pkg::PSZ_W-1:0]   page_size_ff;
   logic [ppa_pkg::CNT_W-1:0]   total_pages_ff;

   logic [2:0]                  state_ff, state_in;
   logic [IDX_W-1:0]            sweep_ff, sweep_in;
   logic [ppa_pkg::CNT_W-1:0]   free_count_ff, free_count_in;
   logic [ppa_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic [2:0]                  res_status_ff, res_status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ppa_pkg::ppa_rsp_type        rsp_data_ff, rsp_data_in;

   logic [ppa_pkg::PS_W-1:0]    ps_eff;
   logic [ppa_pkg::CNT_W-1:0]   total_eff;
   logic [ppa_pkg::ADDR_W:0]    offset;

   logic [IDX_W-1:0]            stack_mem [MAX_PAGES];
   logic                        map_mem [MAX_PAGES];
   logic [IDX_W-1:0]            stack_q;
   logic                        map_q;
   logic                        stack_we;
   logic [IDX_W-1:0]            stack_waddr;
   logic [IDX_W-1:0]            stack_wdata;
   logic [IDX_W-1:0]            stack_raddr;
   logic                        map_we;
   logic [IDX_W-1:0]            map_waddr;
   logic                        map_wdata;
   logic [IDX_W-1:0]            map_raddr;

   ppa_pkg::ppa_unit_cmd_type   unit_cmd;
   logic [ppa_pkg::ADDR_W-1:0]  unit_a;
   logic                        unit_done;
   logic [ppa_pkg::ADDR_W-1:0]  unit_acc;
   logic [ppa_pkg::ADDR_W-1:0]  unit_quo;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff   <= '0;
         page_size_ff   <= ppa_pkg::PSZ_W'(64);
         total_pages_ff <= ppa_pkg::CNT_W'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            ppa_pkg::CSR_POOL_BASE:   pool_base_ff   <= csr_data;
            ppa_pkg::CSR_PAGE_SIZE:   page_size_ff   <= csr_data[ppa_pkg::PSZ_W-1:0];
            ppa_pkg::CSR_TOTAL_PAGES: total_pages_ff <= csr_data[ppa_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // page size rounded up to a multiple of eight bytes, zero acts as eight
   always_comb begin
      if (page_size_ff == '0) begin
         ps_eff = ppa_pkg::PS_W'(8);
      end else begin
         ps_eff = {(15'(page_size_ff[ppa_pkg::PSZ_W-1:3]) + 15'(|page_size_ff[2:0])), 3'b000};
      end
   end

   assign total_eff = (32'(total_pages_ff) > 32'(MAX_PAGES)) ?
                      ppa_pkg::CNT_W'(MAX_PAGES) : total_pages_ff;

   assign offset = {1'b0, req_payload.page_address} - {1'b0, pool_base_ff};

   ppa_shift_add_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .cmd    (unit_cmd),
      .oper_a (unit_a),
      .oper_b (ps_eff),
      .done   (unit_done),
      .acc    (unit_acc),
      .quo    (unit_quo)
   );

   // free stack and allocated-bit map
   assign stack_raddr = IDX_W'(free_count_ff - 1'b1);
   assign map_raddr   = unit_quo[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_q <= stack_mem[stack_raddr];
   end

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_waddr] <= map_wdata;
      end
      map_q <= map_mem[map_raddr];
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      free_count_in = free_count_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_data_in   = rsp_data_ff;
      unit_cmd      = '0;
      unit_a        = 32'(stack_q);
      stack_we      = 1'b0;
      stack_waddr   = sweep_ff;
      stack_wdata   = sweep_ff;
      map_we        = 1'b0;
      map_waddr     = sweep_ff;
      map_wdata     = 1'b0;
      case (state_ff)
         ST_CLEAR, ST_INIT: begin
            map_we   = 1'b1;
            stack_we = (32'(sweep_ff) < 32'(total_eff));
            if (sweep_ff == SWEEP_LAST) begin
               sweep_in = '0;
               if (state_ff == ST_INIT) begin
                  free_count_in = total_eff;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_addr_in   = '0;
               res_status_in = ppa_pkg::STS_OK;
               case (req_payload.kind)
                  ppa_pkg::KIND_INIT: begin
                     state_in = ST_INIT;
                  end
                  ppa_pkg::KIND_ALLOC: begin
                     if (free_count_ff == '0 || 32'(free_count_ff) > 32'(MAX_PAGES)) begin
                        res_status_in = ppa_pkg::STS_EMPTY;
                        state_in      = ST_DONE;
                     end else begin
                        free_count_in = free_count_ff - 1'b1;
                        state_in      = ST_ALLOC_RD;
                     end
                  end
                  ppa_pkg::KIND_FREE: begin
                     if (offset[ppa_pkg::ADDR_W]) begin
                        res_status_in = ppa_pkg::STS_BELOW_BASE;
                        state_in      = ST_DONE;
                     end else begin
                        unit_cmd.start  = 1'b1;
                        unit_cmd.divide = 1'b1;
                        unit_a          = offset[ppa_pkg::ADDR_W-1:0];
                        state_in        = ST_FREE_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_ALLOC_RD: begin
            unit_cmd.start = 1'b1;
            map_we         = 1'b1;
            map_waddr      = stack_q;
            map_wdata      = 1'b1;
            state_in       = ST_ALLOC_MUL;
         end
         ST_ALLOC_MUL: begin
            if (unit_done) begin
               res_addr_in = pool_base_ff + unit_acc;
               state_in    = ST_DONE;
            end
         end
         ST_FREE_DIV: begin
            if (unit_done) begin
               if (unit_acc != '0) begin
                  res_status_in = ppa_pkg::STS_MISALIGNED;
                  state_in      = ST_DONE;
               end else if (unit_quo >= 32'(total_eff)) begin
                  res_status_in = ppa_pkg::STS_OUT_OF_RANGE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_FREE_MAP;
               end
            end
         end
         ST_FREE_MAP: begin
            if (!map_q) begin
               res_status_in = ppa_pkg::STS_NOT_ALLOC;
            end else begin
               map_we    = 1'b1;
               map_waddr = unit_quo[IDX_W-1:0];
               if (32'(free_count_ff) < 32'(MAX_PAGES)) begin
                  stack_we      = 1'b1;
                  stack_waddr   = IDX_W'(free_count_ff);
                  stack_wdata   = unit_quo[IDX_W-1:0];
                  free_count_in = free_count_ff + 1'b1;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.alloc_address = res_addr_ff;
               rsp_data_in.status        = res_status_ff;
               rsp_data_in.free_pages    = free_count_ff;
               rsp_data_in.all_pages     = total_eff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_ff      <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

[rtl/ppa_checker.sv]
// port-level assertions for the page pool allocator and their bind
module ppa_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ppa_pkg::ppa_rsp_type  rsp_payload
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // a failed request carries a zero address
   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != ppa_pkg::STS_OK |-> rsp_payload.alloc_address == '0)
      else $error("failed request returned an address");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // clearing pass after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready && !rsp_valid)
      else $error("ready during clearing pass");

   // status codes stay in range
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= ppa_pkg::STS_NOT_ALLOC)
      else $error("invalid status code");

endmodule

bind page_pool_allocator_top ppa_checker u_ppa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[verif/page_pool_allocator_checker.sv]
`timescale 1ns / 100ps
// request/reply checker for the page pool allocator: tracks registers, predicts and compares
module page_pool_allocator_checker #(
   parameter int MAX_PAGES = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  ppa_pkg::ppa_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ppa_pkg::ppa_rsp_type rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [1:0]           csr_index,
   input  logic [31:0]          csr_data,
   output int                   fail_count,
   output int                   waiting_results
);

   localparam int IDX_W = $clog2(MAX_PAGES);
   localparam int PS_W  = ppa_pkg::PS_W;
   localparam int PSZ_W = ppa_pkg::PSZ_W;
   localparam int CNT_W = ppa_pkg::CNT_W;

   logic [31:0]          pool_base;
   logic [PSZ_W-1:0]     page_size;
   logic [CNT_W-1:0]     total_pages;
   logic [IDX_W-1:0]     free_stack [MAX_PAGES];
   logic [CNT_W-1:0]     free_count;
   logic [MAX_PAGES-1:0] alloc_map;
   ppa_pkg::ppa_rsp_type pending_replies [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic ppa_pkg::ppa_rsp_type pool_reply(input ppa_pkg::ppa_req_type rq);
      ppa_pkg::ppa_rsp_type rp;
      logic [PS_W-1:0]  page_bytes;
      logic [CNT_W-1:0] page_count;
      logic [31:0]      offset;
      logic [31:0]      page_no;
      logic [IDX_W-1:0] slot;
      int               i;
      page_bytes = (PS_W'(page_size) + PS_W'(7)) & ~PS_W'(7);
      if (page_bytes == '0) begin
         page_bytes = PS_W'(8);
      end
      page_count = (total_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : total_pages;
      rp = '0;
      rp.status = ppa_pkg::STS_OK;
      case (rq.kind)
         ppa_pkg::KIND_INIT: begin
            alloc_map = '0;
            for (i = 0; i < page_count; i++) begin
               free_stack[i] = IDX_W'(i);
            end
            free_count = page_count;
         end
         ppa_pkg::KIND_ALLOC: begin
            if (free_count == 0 || free_count > MAX_PAGES) begin
               rp.status = ppa_pkg::STS_EMPTY;
            end else begin
               free_count--;
               slot = free_stack[free_count];
               alloc_map[slot] = 1'b1;
               rp.alloc_address = pool_base + 32'(slot) * 32'(page_bytes);
            end
         end
         ppa_pkg::KIND_FREE: begin
            if (rq.page_address < pool_base) begin
               rp.status = ppa_pkg::STS_BELOW_BASE;
            end else begin
               offset = rq.page_address - pool_base;
               if (offset % 32'(page_bytes) != 0) begin
                  rp.status = ppa_pkg::STS_MISALIGNED;
               end else begin
                  page_no = offset / 32'(page_bytes);
                  if (page_no >= 32'(page_count)) begin
                     rp.status = ppa_pkg::STS_OUT_OF_RANGE;
                  end else if (!alloc_map[page_no[IDX_W-1:0]]) begin
                     rp.status = ppa_pkg::STS_NOT_ALLOC;
                  end else begin
                     alloc_map[page_no[IDX_W-1:0]] = 1'b0;
                     if (free_count < MAX_PAGES) begin
                        free_stack[free_count] = page_no[IDX_W-1:0];
                        free_count++;
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rp.free_pages = free_count;
      rp.all_pages = page_count;
      return rp;
   endfunction

   always @(posedge clock) begin : track
      ppa_pkg::ppa_rsp_type want;
      int          i;
      if (reset) begin
         pool_base = '0;
         page_size = PSZ_W'(64);
         total_pages = CNT_W'(1024);
         for (i = 0; i < MAX_PAGES; i++) begin
            free_stack[i] = '0;
         end
         free_count = '0;
         alloc_map = '0;
         pending_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("unexpected reply", rsp_payload.alloc_address, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_payload.alloc_address !== want.alloc_address) begin
                  report_mismatch("alloc_address", rsp_payload.alloc_address,
                                  want.alloc_address);
               end
               if (rsp_payload.status !== want.status) begin
                  report_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
               end
               if (rsp_payload.free_pages !== want.free_pages) begin
                  report_mismatch("free_pages", 32'(rsp_payload.free_pages),
                                  32'(want.free_pages));
               end
               if (rsp_payload.all_pages !== want.all_pages) begin
                  report_mismatch("all_pages", 32'(rsp_payload.all_pages),
                                  32'(want.all_pages));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ppa_pkg::CSR_POOL_BASE:   pool_base = csr_data;
               ppa_pkg::CSR_PAGE_SIZE:   page_size = csr_data[PSZ_W-1:0];
               ppa_pkg::CSR_TOTAL_PAGES: total_pages = csr_data[CNT_W-1:0];
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready) begin
            pending_replies.push_back(pool_reply(req_payload));
         end
      end
      waiting_results = pending_replies.size();
   end

endmodule

[verif/page_pool_allocator_top_test.sv]
`timescale 1ns / 100ps
// testbench top for the page pool allocator: stimulus, handshake pacing and verdict
module page_pool_allocator_top_test;

   localparam int MAX_PAGES = 1024;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int RSP_LONG_HOLD = 400;
   localparam int PHASE_ITEMS = 97;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   ppa_pkg::ppa_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   ppa_pkg::ppa_rsp_type rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [1:0]           csr_index = '0;
   logic [31:0]          csr_data = '0;

   int          fail_count;
   int          waiting_results;
   int          cycle_count = 0;
   int          hold_asked = 0;
   int          hold_given = 0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;
   logic [31:0] cur_base;
   logic [31:0] cur_bytes;
   int          cur_count;
   logic [31:0] held_pages [$];
   logic [1:0]  sent_kinds [$];
   logic [1:0]  done_kind;

   always #10 clock = ~clock;

   page_pool_allocator_top #(
      .MAX_PAGES(MAX_PAGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   page_pool_allocator_checker #(
      .MAX_PAGES(MAX_PAGES)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count),
      .waiting_results(waiting_results)
   );

   // remember pages handed out so later frees can return them
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready && sent_kinds.size() > 0) begin
         done_kind = sent_kinds.pop_front();
         if (done_kind == ppa_pkg::KIND_ALLOC && rsp_payload.status == ppa_pkg::STS_OK) begin
            held_pages.push_back(rsp_payload.alloc_address);
         end
      end
   end

   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (hold_asked != hold_given) begin
            hold_given++;
            rsp_ready <= 1'b0;
            repeat (RSP_LONG_HOLD - 1) @(negedge clock);
         end else if (rsp_steady) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 63) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(20, 80)) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("page_pool_allocator_top_test: errors");
      $finish;
   end

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (req_steady || r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(input logic [1:0] kind, input logic [31:0] address);
      int                   gap;
      ppa_pkg::ppa_req_type item;
      gap = sender_gap();
      item.kind = kind;
      item.page_address = address;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_kinds.push_back(kind);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (waiting_results != 0) @(negedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_index <= index;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_pool(input logic [31:0] base, input logic [31:0] size,
                           input logic [31:0] count);
      settle();
      write_register(ppa_pkg::CSR_POOL_BASE, base);
      write_register(ppa_pkg::CSR_PAGE_SIZE, size);
      write_register(ppa_pkg::CSR_TOTAL_PAGES, count);
      cur_base = base;
      cur_bytes = ((size & 32'h1FFFF) + 32'd7) & ~32'd7;
      if (cur_bytes == 0) begin
         cur_bytes = 32'd8;
      end
      cur_count = int'(count & 32'h7FF);
      if (cur_count > MAX_PAGES) begin
         cur_count = MAX_PAGES;
      end
      held_pages.delete();
   endtask

   task automatic random_item();
      int          r;
      int          pick;
      logic [31:0] where;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         held_pages.delete();
         send_request(ppa_pkg::KIND_INIT, $urandom());
      end else if (r < 5) begin
         send_request(KIND_UNUSED, $urandom());
      end else if (r < 50) begin
         send_request(ppa_pkg::KIND_ALLOC, $urandom());
      end else if (r < 80 && held_pages.size() > 0) begin
         pick = $urandom_range(0, held_pages.size() - 1);
         where = held_pages[pick];
         // an occasional double free keeps the page listed
         if ($urandom_range(0, 9) != 0) begin
            held_pages.delete(pick);
         end
         send_request(ppa_pkg::KIND_FREE, where);
      end else if (r < 92) begin
         where = cur_base + $urandom_range(0, cur_count + 1) * cur_bytes;
         send_request(ppa_pkg::KIND_FREE, where);
      end else begin
         case ($urandom_range(0, 2))
            0: where = $urandom();
            1: where = cur_base + $urandom_range(1, cur_bytes - 1);
            default: where = cur_base - $urandom_range(1, 4096);
         endcase
         send_request(ppa_pkg::KIND_FREE, where);
      end
   endtask

   task automatic run_phase(input logic [31:0] base, input logic [31:0] size,
                            input logic [31:0] count, input bit steady, input bit long_hold);
      set_pool(base, size, count);
      req_steady = steady;
      rsp_steady = steady;
      if (long_hold) begin
         hold_asked++;
      end
      send_request(ppa_pkg::KIND_INIT, $urandom());
      repeat (PHASE_ITEMS - 1) random_item();
   endtask

   initial begin : stimulus
      cur_base = '0;
      cur_bytes = 32'd64;
      cur_count = MAX_PAGES;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pool not yet initialized, then initialized with the reset configuration
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0040);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0041);
      send_request(ppa_pkg::KIND_FREE, 32'h0001_0000);
      send_request(KIND_UNUSED, 32'hFFFF_FFFF);
      send_request(ppa_pkg::KIND_INIT, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_FREE, 32'd1023 * 32'd64);
      send_request(ppa_pkg::KIND_FREE, 32'd1023 * 32'd64);
      send_request(ppa_pkg::KIND_FREE, 32'hFFFF_FFFF);
      send_request(ppa_pkg::KIND_FREE, 32'hFFFF_FFC0);

      // 64 KiB page, two pages, second address wraps past zero
      set_pool(32'hFFFF_0000, 32'h0001_0000, 32'd2);
      send_request(ppa_pkg::KIND_INIT, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0000);
      send_request(ppa_pkg::KIND_FREE, 32'hFFFF_0000);
      send_request(ppa_pkg::KIND_FREE, 32'hFFFF_0008);

      // odd page size rounds up, single page pool
      set_pool(32'h0000_0080, 32'd13, 32'd1);
      send_request(ppa_pkg::KIND_INIT, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0090);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0080);

      // zero page size and empty pool
      set_pool(32'h0000_0080, 32'd0, 32'd0);
      send_request(ppa_pkg::KIND_INIT, 32'h0);
      send_request(ppa_pkg::KIND_ALLOC, 32'h0);
      send_request(ppa_pkg::KIND_FREE, 32'h0000_0080);

      run_phase($urandom(), 32'd8, 32'd2, 1'b0, 1'b1);
      run_phase(32'h0, 32'd64, 32'd1024, 1'b1, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'd8, $urandom_range(2, 16), 1'b0, 1'b0);
      run_phase($urandom(), $urandom_range(1, 4096), $urandom_range(2, 64), 1'b0, 1'b1);
      run_phase($urandom(), 32'h0001_0000, 32'd2047, 1'b0, 1'b0);
      run_phase(32'h0000_0080, $urandom_range(8, 256), $urandom_range(2, 300), 1'b0, 1'b0);

      settle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("page_pool_allocator_top_test: clean");
      end else begin
         $display("page_pool_allocator_top_test: errors");
      end
      $finish;
   end

endmodule
